// File: rtl/core/tps_pkg.sv
// Shared types and constants for the topological sort engine.
// Holds command and status structs, controller state type and field codes.
// No dependencies.
package tps_pkg;

   localparam int MAX_VERTICES_DEF = 32;
   localparam int MAX_EDGES_DEF    = 64;

   localparam int FUNC_W   = 2;
   localparam int VTX_W    = 5;
   localparam int CNT_W    = 6;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;

   localparam logic [CNT_W-1:0] VCOUNT_RESET = 6'd32;

   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VERTEX  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_REV,
      ST_DEG_CLR,
      ST_CNT_RD,
      ST_CNT_DEG,
      ST_CNT_WR,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_POP,
      ST_EMIT,
      ST_WALK_RD,
      ST_WALK_SRC,
      ST_WALK_DEG,
      ST_SUMMARY
   } tps_state_type;

   typedef struct packed {
      logic take_item;
      logic add_rev;
      logic run_start;
      logic idx_clr;
      logic vtx_next;
      logic edge_next;
      logic deg_zero_wr;
      logic edge_rd;
      logic deg_rd_tgt;
      logic deg_inc_wr;
      logic deg_rd_vtx;
      logic scan_chk;
      logic stack_pop;
      logic emit_vtx;
      logic walk_dec;
      logic emit_sum;
   } tps_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic deg_clr_last;
      logic edges_done;
      logic scan_done;
      logic stack_empty;
      logic src_match;
      logic rev_needed;
   } tps_sts_type;

endpackage

// File: rtl/core/tps_ctrl.sv
// Controller state machine for the topological sort engine.
// Sequences edge loading and the sort run; depends on tps_pkg.
module tps_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [tps_pkg::FUNC_W-1:0]     req_func,
   output logic                           req_stall,
   input  tps_pkg::tps_sts_type           sts,
   output tps_pkg::tps_cmd_type           cmd
);
   import tps_pkg::*;

   tps_state_type state_ff;
   tps_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = !((state_ff == ST_IDLE) && sts.slot_free);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.slot_free) begin
               if (req_func == FUNC_RUN) begin
                  cmd.run_start = 1'b1;
                  state_in      = ST_DEG_CLR;
               end else begin
                  cmd.take_item = 1'b1;
                  if (sts.rev_needed) begin
                     state_in = ST_ADD_REV;
                  end
               end
            end
         end
         ST_ADD_REV: begin
            cmd.add_rev = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_DEG_CLR: begin
            cmd.deg_zero_wr = 1'b1;
            cmd.vtx_next    = 1'b1;
            if (sts.deg_clr_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_CNT_RD;
            end
         end
         ST_CNT_RD: begin
            if (sts.edges_done) begin
               state_in = ST_SCAN_RD;
            end else begin
               cmd.edge_rd = 1'b1;
               state_in    = ST_CNT_DEG;
            end
         end
         ST_CNT_DEG: begin
            cmd.deg_rd_tgt = 1'b1;
            state_in       = ST_CNT_WR;
         end
         ST_CNT_WR: begin
            cmd.deg_inc_wr = 1'b1;
            cmd.edge_next  = 1'b1;
            state_in       = ST_CNT_RD;
         end
         ST_SCAN_RD: begin
            if (sts.scan_done) begin
               state_in = ST_POP;
            end else begin
               cmd.deg_rd_vtx = 1'b1;
               state_in       = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            cmd.scan_chk = 1'b1;
            cmd.vtx_next = 1'b1;
            state_in     = ST_SCAN_RD;
         end
         ST_POP: begin
            if (sts.stack_empty) begin
               state_in = ST_SUMMARY;
            end else begin
               cmd.stack_pop = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold the popped vertex until the result slot frees
            if (sts.slot_free) begin
               cmd.emit_vtx = 1'b1;
               state_in     = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            if (sts.edges_done) begin
               state_in = ST_POP;
            end else begin
               cmd.edge_rd = 1'b1;
               state_in    = ST_WALK_SRC;
            end
         end
         ST_WALK_SRC: begin
            if (sts.src_match) begin
               cmd.deg_rd_tgt = 1'b1;
               state_in       = ST_WALK_DEG;
            end else begin
               cmd.edge_next = 1'b1;
               state_in      = ST_WALK_RD;
            end
         end
         ST_WALK_DEG: begin
            cmd.walk_dec  = 1'b1;
            cmd.edge_next = 1'b1;
            state_in      = ST_WALK_RD;
         end
         ST_SUMMARY: begin
            if (sts.slot_free) begin
               cmd.emit_sum = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/tps_dp.sv
// Datapath for the topological sort engine: edge store, in-degree and
// ready-stack memories, counters and the result register. Depends on tps_pkg.
module tps_dp #(
   parameter int MAX_VERTICES = tps_pkg::MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = tps_pkg::MAX_EDGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tps_pkg::FUNC_W-1:0]       req_func,
   input  logic [tps_pkg::VTX_W-1:0]        req_from_vertex,
   input  logic [tps_pkg::VTX_W-1:0]        req_to_vertex,
   input  logic                             req_both_ways,
   input  logic                             csr_we,
   input  logic [tps_pkg::CNT_W-1:0]        csr_wdata,
   input  tps_pkg::tps_cmd_type             cmd,
   output tps_pkg::tps_sts_type             sts,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [tps_pkg::KIND_W-1:0]       rsp_kind,
   output logic [tps_pkg::VTX_W-1:0]        rsp_vertex,
   output logic [tps_pkg::CNT_W-1:0]        rsp_emitted_count,
   output logic                             rsp_cycle_found,
   output logic [tps_pkg::STATUS_W-1:0]     rsp_status,
   output logic                             rsp_last
);
   import tps_pkg::*;

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int DGW = $clog2(MAX_EDGES + 1);

   // memories
   logic [VTX_W-1:0] edge_src_mem [MAX_EDGES];
   logic [VTX_W-1:0] edge_tgt_mem [MAX_EDGES];
   logic [DGW-1:0]   deg_mem      [MAX_VERTICES];
   logic [VW-1:0]    stk_mem      [MAX_VERTICES];

   // control registers
   logic [CNT_W-1:0] vcount_ff, vcount_in;
   logic [ECW-1:0]   stored_ff, stored_in;
   logic [ECW-1:0]   edge_idx_ff, edge_idx_in;
   logic [CNT_W-1:0] vtx_ff, vtx_in;
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0] emitted_ff, emitted_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [VTX_W-1:0]    rev_src_ff, rev_tgt_ff;
   logic [VW-1:0]       cur_ff;
   logic [VTX_W-1:0]    src_rd_ff, tgt_rd_ff;
   logic [DGW-1:0]      deg_rd_ff;
   logic [VW-1:0]       stk_rd_ff;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [VTX_W-1:0]    vertex_ff, vertex_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                cycle_ff, cycle_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                last_ff, last_in;

   // combinational datapath
   logic [CNT_W-1:0]    vc_eff;
   logic                range_bad, full, add_ok;
   logic [ECW:0]        need, slots_after;
   logic [STATUS_W-1:0] ack_status;
   logic                rsp_load;
   logic                ewr_en;
   logic [VTX_W-1:0]    ewr_src, ewr_tgt;
   logic [VW+VTX_W-1:0] tgt_x, src_x, cur_x;
   logic [VW+VTX_W-1:0] stk_x;
   logic [VW-1:0]       tgt_v;
   logic                deg_rd_en, deg_wr_en;
   logic [VW-1:0]       deg_rd_addr, deg_wr_addr;
   logic [DGW-1:0]      deg_wr_data;
   logic                push_en;
   logic [VW-1:0]       push_data;
   logic [CNT_W-1:0]    depth_dec;

   assign vc_eff = (vcount_ff > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_ff;

   assign range_bad   = ({1'b0, req_from_vertex} >= vc_eff) ||
                        ({1'b0, req_to_vertex} >= vc_eff);
   assign need        = req_both_ways ? (ECW+1)'(2) : (ECW+1)'(1);
   assign slots_after = {1'b0, stored_ff} + need;
   assign full        = slots_after > (ECW+1)'(MAX_EDGES);
   assign add_ok      = (req_func == FUNC_ADD) && !range_bad && !full;

   always_comb begin
      ack_status = STATUS_OK;
      if (req_func == FUNC_ADD) begin
         if (range_bad) begin
            ack_status = STATUS_RANGE;
         end else if (full) begin
            ack_status = STATUS_FULL;
         end
      end
   end

   // vertex values widened to a common width before narrowing
   assign tgt_x     = {{VW{1'b0}}, tgt_rd_ff};
   assign src_x     = {{VW{1'b0}}, src_rd_ff};
   assign cur_x     = {{VTX_W{1'b0}}, cur_ff};
   assign stk_x     = {{VTX_W{1'b0}}, stk_rd_ff};
   assign tgt_v     = tgt_x[VW-1:0];
   assign depth_dec = depth_ff - CNT_W'(1);

   assign sts.slot_free    = !rsp_valid_ff || !rsp_stall;
   assign sts.deg_clr_last = vtx_ff == CNT_W'(MAX_VERTICES - 1);
   assign sts.edges_done   = edge_idx_ff == stored_ff;
   assign sts.scan_done    = vtx_ff == vc_eff;
   assign sts.stack_empty  = depth_ff == '0;
   assign sts.src_match    = src_x == cur_x;
   assign sts.rev_needed   = add_ok && req_both_ways;

   // edge store write
   always_comb begin
      ewr_en  = 1'b0;
      ewr_src = req_from_vertex;
      ewr_tgt = req_to_vertex;
      if (cmd.take_item && add_ok) begin
         ewr_en = 1'b1;
      end else if (cmd.add_rev) begin
         ewr_en  = 1'b1;
         ewr_src = rev_src_ff;
         ewr_tgt = rev_tgt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ewr_en) begin
         edge_src_mem[stored_ff[EAW-1:0]] <= ewr_src;
         edge_tgt_mem[stored_ff[EAW-1:0]] <= ewr_tgt;
      end
      if (cmd.edge_rd) begin
         src_rd_ff <= edge_src_mem[edge_idx_ff[EAW-1:0]];
         tgt_rd_ff <= edge_tgt_mem[edge_idx_ff[EAW-1:0]];
      end
      if (cmd.take_item) begin
         rev_src_ff <= req_to_vertex;
         rev_tgt_ff <= req_from_vertex;
      end
   end

   // in-degree memory ports
   always_comb begin
      deg_rd_en   = cmd.deg_rd_vtx || cmd.deg_rd_tgt;
      deg_rd_addr = cmd.deg_rd_vtx ? vtx_ff[VW-1:0] : tgt_v;
      deg_wr_en   = 1'b0;
      deg_wr_addr = tgt_v;
      deg_wr_data = deg_rd_ff + DGW'(1);
      if (cmd.deg_zero_wr) begin
         deg_wr_en   = 1'b1;
         deg_wr_addr = vtx_ff[VW-1:0];
         deg_wr_data = '0;
      end else if (cmd.deg_inc_wr) begin
         deg_wr_en = 1'b1;
      end else if (cmd.walk_dec && (deg_rd_ff != '0)) begin
         deg_wr_en   = 1'b1;
         deg_wr_data = deg_rd_ff - DGW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (deg_wr_en) begin
         deg_mem[deg_wr_addr] <= deg_wr_data;
      end
      if (deg_rd_en) begin
         deg_rd_ff <= deg_mem[deg_rd_addr];
      end
   end

   // ready stack
   always_comb begin
      push_en   = 1'b0;
      push_data = vtx_ff[VW-1:0];
      if (cmd.scan_chk && (deg_rd_ff == '0)) begin
         push_en = 1'b1;
      end else if (cmd.walk_dec && (deg_rd_ff == DGW'(1))) begin
         push_en   = 1'b1;
         push_data = tgt_v;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         stk_mem[depth_ff[VW-1:0]] <= push_data;
      end
      if (cmd.stack_pop) begin
         stk_rd_ff <= stk_mem[depth_dec[VW-1:0]];
      end
      if (cmd.emit_vtx) begin
         cur_ff <= stk_rd_ff;
      end
   end

   // counters
   always_comb begin
      vcount_in   = vcount_ff;
      stored_in   = stored_ff;
      edge_idx_in = edge_idx_ff;
      vtx_in      = vtx_ff;
      depth_in    = depth_ff;
      emitted_in  = emitted_ff;

      if (csr_we) begin
         vcount_in = csr_wdata;
      end
      if (ewr_en) begin
         stored_in = stored_ff + ECW'(1);
      end else if (cmd.take_item && (req_func == FUNC_CLEAR)) begin
         stored_in = '0;
      end
      if (cmd.vtx_next) begin
         vtx_in = vtx_ff + CNT_W'(1);
      end
      if (cmd.edge_next) begin
         edge_idx_in = edge_idx_ff + ECW'(1);
      end
      if (cmd.emit_vtx) begin
         edge_idx_in = '0;
         emitted_in  = emitted_ff + CNT_W'(1);
      end
      if (push_en) begin
         depth_in = depth_ff + CNT_W'(1);
      end else if (cmd.stack_pop) begin
         depth_in = depth_dec;
      end
      if (cmd.idx_clr) begin
         vtx_in      = '0;
         edge_idx_in = '0;
      end
      if (cmd.run_start) begin
         vtx_in     = '0;
         depth_in   = '0;
         emitted_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff   <= VCOUNT_RESET;
         stored_ff   <= '0;
         edge_idx_ff <= '0;
         vtx_ff      <= '0;
         depth_ff    <= '0;
         emitted_ff  <= '0;
      end else begin
         vcount_ff   <= vcount_in;
         stored_ff   <= stored_in;
         edge_idx_ff <= edge_idx_in;
         vtx_ff      <= vtx_in;
         depth_ff    <= depth_in;
         emitted_ff  <= emitted_in;
      end
   end

   // result register
   assign rsp_load = cmd.take_item || cmd.emit_vtx || cmd.emit_sum;

   always_comb begin
      kind_in   = KIND_ACK;
      vertex_in = '0;
      count_in  = '0;
      cycle_in  = 1'b0;
      status_in = STATUS_OK;
      last_in   = 1'b1;
      if (cmd.emit_vtx) begin
         kind_in   = KIND_VERTEX;
         vertex_in = stk_x[VTX_W-1:0];
         last_in   = 1'b0;
      end else if (cmd.emit_sum) begin
         kind_in  = KIND_SUMMARY;
         count_in = emitted_ff;
         cycle_in = emitted_ff < vc_eff;
      end else begin
         status_in = ack_status;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         kind_ff   <= kind_in;
         vertex_ff <= vertex_in;
         count_ff  <= count_in;
         cycle_ff  <= cycle_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_vertex        = vertex_ff;
   assign rsp_emitted_count = count_ff;
   assign rsp_cycle_found   = cycle_ff;
   assign rsp_status        = status_ff;
   assign rsp_last          = last_ff;

endmodule

// File: rtl/core/kahn_topological_sort.sv
// Kahn topological sort engine, top level. Edge add/clear: acknowledge in the cycle
// after acceptance; an undirected add writes its reverse edge in a further ST_ADD_REV
// state (one edge store write port). A run clears the in-degree memory, counts in-degrees
// over the edge store, scans for ready vertices, then pops and emits each vertex while
// walking the edge store for its out-edges, and last loads its summary.
// Synchronous reset empties the edge store and sets vertex_count to 32; memories are not cleared.
module kahn_topological_sort #(
   parameter int MAX_VERTICES = tps_pkg::MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = tps_pkg::MAX_EDGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tps_pkg::FUNC_W-1:0]       req_func,
   input  logic [tps_pkg::VTX_W-1:0]        req_from_vertex,
   input  logic [tps_pkg::VTX_W-1:0]        req_to_vertex,
   input  logic                             req_both_ways,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tps_pkg::KIND_W-1:0]       rsp_kind,
   output logic [tps_pkg::VTX_W-1:0]        rsp_vertex,
   output logic [tps_pkg::CNT_W-1:0]        rsp_emitted_count,
   output logic                             rsp_cycle_found,
   output logic [tps_pkg::STATUS_W-1:0]     rsp_status,
   output logic                             rsp_last,
   input  logic                             csr_we,
   input  logic [tps_pkg::CNT_W-1:0]        csr_wdata
);
   import tps_pkg::*;

   tps_cmd_type cmd;
   tps_sts_type sts;

   tps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tps_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_func          (req_func),
      .req_from_vertex   (req_from_vertex),
      .req_to_vertex     (req_to_vertex),
      .req_both_ways     (req_both_ways),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_vertex        (rsp_vertex),
      .rsp_emitted_count (rsp_emitted_count),
      .rsp_cycle_found   (rsp_cycle_found),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   // never pop an empty ready stack
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.stack_pop |-> !sts.stack_empty)
      else $error("pop issued on empty ready stack");

   // a result is loaded only into a free slot
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_item || cmd.emit_vtx || cmd.emit_sum) |-> sts.slot_free)
      else $error("result loaded over a pending transaction");

   // an accepted non-run transaction is acknowledged in the next cycle
   a_ack_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_func != FUNC_RUN)) |=>
         (rsp_valid && (rsp_kind == KIND_ACK) && rsp_last))
      else $error("missing acknowledge after accepted transaction");

   // vertex results never close an item, summaries always do
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_VERTEX) != rsp_last))
      else $error("last flag inconsistent with result kind");

endmodule

// File: dv/kahn_topological_sort_tb.sv
// Self-checking testbench for kahn_topological_sort: directed table, then random
// edge loads, runs and clears under several idle mixes and vertex counts.
// Depends on tps_pkg and the kahn_topological_sort RTL only.
module kahn_topological_sort_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tps_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int MAX_E       = MAX_EDGES_DEF;
   localparam int MAX_V       = MAX_VERTICES_DEF;
   localparam int QUIET_LIMIT = 20000;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [VTX_W-1:0]    vertex;
      logic [CNT_W-1:0]    emitted_count;
      logic                cycle_found;
      logic [STATUS_W-1:0] status;
      logic                last;
   } topo_result_type;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [FUNC_W-1:0]   func;
      logic [VTX_W-1:0]    src;
      logic [VTX_W-1:0]    dst;
      logic                both;
      logic [7:0]          reps;
      logic                pinned;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    cfg;
   } stim_row_type;

   localparam int PLAN_ROWS = 33;
   localparam stim_row_type PLAN [PLAN_ROWS] = '{
      '{ROW_ITEM, FUNC_RUN,    5'd0,  5'd0,  1'b0, 8'd1,  1'b0, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_ADD,    5'd0,  5'd31, 1'b0, 8'd1,  1'b1, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_ADD,    5'd31, 5'd0,  1'b1, 8'd1,  1'b1, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_RUN,    5'd0,  5'd0,  1'b0, 8'd1,  1'b0, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_UNUSED, 5'd31, 5'd31, 1'b1, 8'd1,  1'b1, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_CLEAR,  5'd0,  5'd0,  1'b0, 8'd1,  1'b1, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_ADD,    5'd5,  5'd5,  1'b1, 8'd1,  1'b1, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_RUN,    5'd0,  5'd0,  1'b0, 8'd1,  1'b0, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_CLEAR,  5'd0,  5'd0,  1'b0, 8'd1,  1'b1, STATUS_OK,    6'd0},
      '{ROW_CFG,  FUNC_ADD,    5'd0,  5'd0,  1'b0, 8'd0,  1'b0, STATUS_OK,    6'd4},
      '{ROW_ITEM, FUNC_ADD,    5'd4,  5'd0,  1'b0, 8'd1,  1'b1, STATUS_RANGE, 6'd0},
      '{ROW_ITEM, FUNC_ADD,    5'd0,  5'd31, 1'b1, 8'd1,  1'b1, STATUS_RANGE, 6'd0},
      '{ROW_ITEM, FUNC_ADD,    5'd0,  5'd1,  1'b1, 8'd31, 1'b0, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_ADD,    5'd2,  5'd3,  1'b0, 8'd1,  1'b1, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_ADD,    5'd2,  5'd3,  1'b1, 8'd1,  1'b1, STATUS_FULL,  6'd0},
      '{ROW_ITEM, FUNC_ADD,    5'd3,  5'd2,  1'b0, 8'd1,  1'b1, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_ADD,    5'd3,  5'd3,  1'b0, 8'd1,  1'b1, STATUS_FULL,  6'd0},
      '{ROW_ITEM, FUNC_ADD,    5'd3,  5'd4,  1'b0, 8'd1,  1'b1, STATUS_RANGE, 6'd0},
      '{ROW_ITEM, FUNC_RUN,    5'd0,  5'd0,  1'b0, 8'd1,  1'b0, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_CLEAR,  5'd0,  5'd0,  1'b0, 8'd1,  1'b1, STATUS_OK,    6'd0},
      '{ROW_CFG,  FUNC_ADD,    5'd0,  5'd0,  1'b0, 8'd0,  1'b0, STATUS_OK,    6'd32},
      '{ROW_ITEM, FUNC_ADD,    5'd0,  5'd3,  1'b0, 8'd1,  1'b1, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_ADD,    5'd3,  5'd20, 1'b0, 8'd1,  1'b1, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_ADD,    5'd20, 5'd1,  1'b0, 8'd1,  1'b1, STATUS_OK,    6'd0},
      '{ROW_CFG,  FUNC_ADD,    5'd0,  5'd0,  1'b0, 8'd0,  1'b0, STATUS_OK,    6'd2},
      '{ROW_ITEM, FUNC_RUN,    5'd0,  5'd0,  1'b0, 8'd1,  1'b0, STATUS_OK,    6'd0},
      '{ROW_CFG,  FUNC_ADD,    5'd0,  5'd0,  1'b0, 8'd0,  1'b0, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_ADD,    5'd0,  5'd0,  1'b0, 8'd1,  1'b1, STATUS_RANGE, 6'd0},
      '{ROW_ITEM, FUNC_RUN,    5'd0,  5'd0,  1'b0, 8'd1,  1'b0, STATUS_OK,    6'd0},
      '{ROW_CFG,  FUNC_ADD,    5'd0,  5'd0,  1'b0, 8'd0,  1'b0, STATUS_OK,    6'd63},
      '{ROW_ITEM, FUNC_ADD,    5'd31, 5'd31, 1'b0, 8'd1,  1'b1, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_RUN,    5'd0,  5'd0,  1'b0, 8'd1,  1'b0, STATUS_OK,    6'd0},
      '{ROW_ITEM, FUNC_CLEAR,  5'd0,  5'd0,  1'b0, 8'd1,  1'b1, STATUS_OK,    6'd0}
   };

   localparam logic [CNT_W-1:0] VC_PLAN [8] = '{6'd32, 6'd7, 6'd63, 6'd1,
                                                6'd16, 6'd2, 6'd32, 6'd5};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func = FUNC_ADD;
   logic [VTX_W-1:0]    req_from_vertex = '0;
   logic [VTX_W-1:0]    req_to_vertex = '0;
   logic                req_both_ways = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [VTX_W-1:0]    rsp_vertex;
   logic [CNT_W-1:0]    rsp_emitted_count;
   logic                rsp_cycle_found;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;
   logic                csr_we = 1'b0;
   logic [CNT_W-1:0]    csr_wdata = '0;

   // sort engine shadow state
   logic [VTX_W-1:0]    edge_from_m [MAX_E];
   logic [VTX_W-1:0]    edge_to_m [MAX_E];
   int unsigned         edge_total = 0;
   logic [CNT_W-1:0]    vcount_model = VCOUNT_RESET;
   topo_result_type     sort_results_due [$];

   logic                pin_on = 1'b0;
   logic [STATUS_W-1:0] pin_status = STATUS_OK;
   int                  send_idle_pct = 0;
   int                  rcv_stall_pct = 0;
   int                  long_hold = 0;
   int                  fail_count = 0;
   int                  quiet_cycles = 0;

   kahn_topological_sort i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_from_vertex   (req_from_vertex),
      .req_to_vertex     (req_to_vertex),
      .req_both_ways     (req_both_ways),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_vertex        (rsp_vertex),
      .rsp_emitted_count (rsp_emitted_count),
      .rsp_cycle_found   (rsp_cycle_found),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int unsigned effective_count();
      return (vcount_model > CNT_W'(MAX_V)) ? MAX_V : vcount_model;
   endfunction

   // append one predicted transaction to the tail of the queue
   function automatic void queue_result(topo_result_type r);
      sort_results_due = {sort_results_due, r};
   endfunction

   function automatic void sort_run();
      int unsigned vc;
      int unsigned depth;
      int unsigned emitted;
      int unsigned hot;
      int unsigned indeg [MAX_V];
      logic [VTX_W-1:0] ready [MAX_V];
      indeg = '{default: 0};
      vc = effective_count();
      for (int e = 0; e < edge_total; e++) indeg[edge_to_m[e]]++;
      depth = 0;
      for (int v = 0; v < vc; v++) begin
         if (indeg[v] == 0) begin
            ready[depth] = VTX_W'(v);
            depth++;
         end
      end
      emitted = 0;
      while (depth > 0) begin
         depth--;
         hot = ready[depth];
         emitted++;
         queue_result('{KIND_VERTEX, VTX_W'(hot), '0, 1'b0, STATUS_OK, 1'b0});
         // walk out-edges in insertion order, releasing targets that reach zero
         for (int e = 0; e < edge_total; e++) begin
            if (edge_from_m[e] == hot && indeg[edge_to_m[e]] != 0) begin
               indeg[edge_to_m[e]]--;
               if (indeg[edge_to_m[e]] == 0 && depth < MAX_V) begin
                  ready[depth] = edge_to_m[e];
                  depth++;
               end
            end
         end
      end
      queue_result('{KIND_SUMMARY, '0, CNT_W'(emitted), emitted < vc, STATUS_OK, 1'b1});
   endfunction

   function automatic void sort_step(logic [FUNC_W-1:0] f, logic [VTX_W-1:0] a,
                                     logic [VTX_W-1:0] b, logic bw);
      int unsigned vc;
      int unsigned need;
      logic [STATUS_W-1:0] st;
      vc = effective_count();
      need = bw ? 2 : 1;
      st = STATUS_OK;
      if (f == FUNC_RUN) begin
         sort_run();
         return;
      end
      if (f == FUNC_ADD) begin
         if (a >= vc || b >= vc) begin
            st = STATUS_RANGE;
         end else if (edge_total > MAX_E || need > MAX_E - edge_total) begin
            st = STATUS_FULL;
         end else begin
            edge_from_m[edge_total] = a;
            edge_to_m[edge_total] = b;
            edge_total++;
            if (bw) begin
               edge_from_m[edge_total] = b;
               edge_to_m[edge_total] = a;
               edge_total++;
            end
         end
      end else if (f == FUNC_CLEAR) begin
         edge_total = 0;
      end
      queue_result('{KIND_ACK, '0, '0, 1'b0, st, 1'b1});
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   function automatic void check_result(topo_result_type got);
      topo_result_type want;
      if (sort_results_due.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected result, expected none, actual kind %0d vertex %0d",
                  $time, got.kind, got.vertex);
         return;
      end
      want = sort_results_due.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("vertex", want.vertex, got.vertex);
      compare_field("emitted_count", want.emitted_count, got.emitted_count);
      compare_field("cycle_found", want.cycle_found, got.cycle_found);
      compare_field("status", want.status, got.status);
      compare_field("last", want.last, got.last);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            check_result('{rsp_kind, rsp_vertex, rsp_emitted_count, rsp_cycle_found,
                           rsp_status, rsp_last});
         if (req_valid && !req_stall) begin
            sort_step(req_func, req_from_vertex, req_to_vertex, req_both_ways);
            // table rows with a typed-in status replace the predicted acknowledge
            if (pin_on) begin
               sort_results_due.delete(sort_results_due.size() - 1);
               queue_result('{KIND_ACK, '0, '0, 1'b0, pin_status, 1'b1});
            end
         end
         if (csr_we) vcount_model = csr_wdata;
      end
   end

   // receiver: random stall, or a counted long hold when one is requested
   always @(negedge clock) begin
      if (long_hold > 0) begin
         rsp_stall <= 1'b1;
         long_hold <= long_hold - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer(input logic [FUNC_W-1:0] f, input logic [VTX_W-1:0] a,
                        input logic [VTX_W-1:0] b, input logic bw, input logic pin,
                        input logic [STATUS_W-1:0] pst);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= f;
      req_from_vertex <= a;
      req_to_vertex <= b;
      req_both_ways <= bw;
      pin_on <= pin;
      pin_status <= pst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sort_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_vertex_count(input logic [CNT_W-1:0] value);
      pause_until_drained();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic pick_random_item(output logic [FUNC_W-1:0] f, output logic [VTX_W-1:0] a,
                                   output logic [VTX_W-1:0] b, output logic bw);
      int unsigned roll;
      int unsigned vc;
      int unsigned x;
      int unsigned y;
      roll = $urandom_range(99);
      vc = effective_count();
      f = FUNC_ADD;
      a = VTX_W'($urandom_range(31));
      b = VTX_W'($urandom_range(31));
      bw = 1'($urandom_range(1));
      if (roll < 8) begin
         f = FUNC_RUN;
      end else if (roll < 10) begin
         f = FUNC_CLEAR;
      end else if (roll < 12) begin
         f = FUNC_UNUSED;
      end else if (roll >= 22 && vc > 0) begin
         x = $urandom_range(vc - 1);
         y = $urandom_range(vc - 1);
         // point most edges upwards so that many runs finish without a cycle
         if ($urandom_range(4) != 0 && x > y) begin
            a = VTX_W'(y);
            b = VTX_W'(x);
         end else begin
            a = VTX_W'(x);
            b = VTX_W'(y);
         end
         bw = ($urandom_range(9) == 0);
      end
   endtask

   initial begin
      logic [FUNC_W-1:0] f;
      logic [VTX_W-1:0]  a;
      logic [VTX_W-1:0]  b;
      logic              bw;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (PLAN[r].kind == ROW_CFG) begin
            set_vertex_count(PLAN[r].cfg);
         end else begin
            for (int n = 0; n < PLAN[r].reps; n++)
               offer(PLAN[r].func, PLAN[r].src, PLAN[r].dst, PLAN[r].both,
                     PLAN[r].pinned, PLAN[r].status);
         end
      end

      for (int ph = 0; ph < 8; ph++) begin
         set_vertex_count(VC_PLAN[ph]);
         @(posedge clock);
         case (ph / 2)
            0: begin
               send_idle_pct = 0;
               rcv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 76;
               rcv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rcv_stall_pct = 76;
            end
            default: begin
               send_idle_pct = 25;
               rcv_stall_pct = 25;
            end
         endcase
         // hold the receiver off while items keep coming, so the input backs up
         if (ph == 0) long_hold = 400;
         for (int k = 0; k < 20; k++) begin
            if (ph == 6 && k == 14) pause_until_drained();
            pick_random_item(f, a, b, bw);
            offer(f, a, b, bw, 1'b0, STATUS_OK);
         end
      end

      pause_until_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
